[rtl/hashed_token_bucket_limiter_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the hashed token bucket limiter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HASHED_TOKEN_BUCKET_LIMITER_TOP_MACROS_SVH
`define HASHED_TOKEN_BUCKET_LIMITER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define HTBL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htbl check failed");

// antecedent implies consequent after the delay given by dly
`define HTBL_ASSERT_DLY(label, clk, rst, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("htbl latency check failed");

`else

`define HTBL_ASSERT_IMP(label, clk, rst, ante, cons)
`define HTBL_ASSERT_DLY(label, clk, rst, ante, dly, cons)

`endif

`endif

[rtl/htbl_pkg.sv]
// ----------------------------------------------------------------------------
// htbl_pkg
// Shared types, widths and constants of the hashed token bucket limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htbl_pkg;

  localparam int TIME_W     = 32;
  localparam int ADDR_W     = 32;
  localparam int TOKEN_W    = 20;
  localparam int RATE_W     = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;
  // low part of elapsed time that can still give a gain within capacity
  localparam int DT_LOW_W   = 20;
  localparam int PROD_W     = DT_LOW_W + RATE_W;

  localparam logic [TOKEN_W-1:0] MILLI_PER_TOKEN = 20'd1000;
  localparam logic [TOKEN_W-1:0] RESET_CAP       = 20'd5000;
  localparam logic [RATE_W-1:0]  RESET_RATE      = 10'd20;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE  = 1'b0,
    CFG_BURST = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [ADDR_W-1:0] source_address;
  } in_t;

  typedef struct packed {
    logic               allowed;
    logic [TOKEN_W-1:0] tokens_left;
  } out_t;

  // one bucket as held in the bucket memory
  typedef struct packed {
    logic [TIME_W-1:0]  last_time;
    logic [TOKEN_W-1:0] tokens;
  } bucket_t;

  // live policing settings
  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [TOKEN_W-1:0] cap;
  } cfg_t;

  function automatic int idx_width(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[rtl/hashed_token_bucket_limiter_top.sv]
// ----------------------------------------------------------------------------
// hashed_token_bucket_limiter_top
// Per-source token bucket policer with one bucket per address residue.
// ----------------------------------------------------------------------------
// One beat is accepted per clock whenever busy is low, with no gaps needed
// between beats, also on the same bucket. Each beat gives exactly one result:
// done rises once the beat has passed the input register, index register,
// payload register, memory read and result register, with the result beside
// it; it is shown for one cycle only and must be captured then. After reset,
// busy stays high while the bucket memory is filled to a full bucket (5000
// milli-tokens, time zero), one entry per cycle; config writes are taken
// during that sweep. Rate and burst should be written only when no beats
// are in flight.
`timescale 1ns / 1ps

`include "hashed_token_bucket_limiter_top_macros.svh"

module hashed_token_bucket_limiter_top #(
  parameter int BUCKET_COUNT = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  htbl_pkg::in_t                     item,
  output logic                              done,
  output htbl_pkg::out_t                    result,
  input  logic                              cfg_write,
  input  logic [htbl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [htbl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import htbl_pkg::*;

  localparam int IDX_W = idx_width(BUCKET_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_COUNT - 1);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   clr_addr;
  cfg_t               cfg;

  logic               p1_valid;
  in_t                p1_item;
  logic               p2_valid;
  logic [TIME_W-1:0]  p2_time;
  logic [IDX_W-1:0]   p2_idx;
  logic               p3_valid;
  logic [TIME_W-1:0]  p3_time;
  logic [IDX_W-1:0]   p3_idx;
  logic               p4_valid;
  logic [TIME_W-1:0]  p4_time;
  logic [IDX_W-1:0]   p4_idx;
  logic               p5_valid;
  logic [IDX_W-1:0]   p5_idx;
  bucket_t            p5_entry;
  logic               p5_allowed;

  bucket_t            ram_rdata;
  bucket_t            ram_wdata;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  bucket_t            cur_entry;
  bucket_t            upd_entry;
  logic               upd_allowed;
  logic               accept;

  assign busy   = (state == ST_CLEAR);
  assign accept = start && !busy;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_IDX) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // configuration registers; capacity kept in milli-tokens
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate <= RESET_RATE;
      cfg.cap  <= RESET_CAP;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RATE:  cfg.rate <= cfg_data;
        CFG_BURST: cfg.cap  <= {{(TOKEN_W-CFG_DATA_W){1'b0}}, cfg_data} * MILLI_PER_TOKEN;
        default: ;
      endcase
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      p5_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
      p5_valid <= p4_valid;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_item <= item;
    end
  end

  // bucket index, registered inside over one stage
  htbl_index #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_index (
    .clk  (clk),
    .addr (p1_item.source_address),
    .idx  (p2_idx)
  );

  // payload stages up to the memory read and the update
  always_ff @(posedge clk) begin
    p2_time <= p1_item.time_ms;
    p3_time <= p2_time;
    p3_idx  <= p2_idx;
    p4_time <= p3_time;
    p4_idx  <= p3_idx;
  end

  // memory write: clearing sweep, else update write-back
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we              = 1'b1;
      ram_waddr           = clr_addr;
      ram_wdata.last_time = '0;
      ram_wdata.tokens    = RESET_CAP;
    end else begin
      ram_we              = p4_valid;
      ram_waddr           = p4_idx;
      ram_wdata           = upd_entry;
    end
  end

  htbl_ram #(
    .WIDTH ($bits(bucket_t)),
    .DEPTH (BUCKET_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (p3_idx),
    .rdata (ram_rdata)
  );

  // the previous beat wrote as this one read: take its bucket instead
  assign cur_entry = (p5_valid && (p5_idx == p4_idx)) ? p5_entry : ram_rdata;

  htbl_update u_update (
    .entry      (cur_entry),
    .time_ms    (p4_time),
    .cfg        (cfg),
    .entry_next (upd_entry),
    .allowed    (upd_allowed)
  );

  // result register, also the forwarding source
  always_ff @(posedge clk) begin
    p5_idx     <= p4_idx;
    p5_entry   <= upd_entry;
    p5_allowed <= upd_allowed;
  end

  assign done               = p5_valid;
  assign result.allowed     = p5_allowed;
  assign result.tokens_left = p5_entry.tokens;

  // checks
  `HTBL_ASSERT_IMP(a_no_result_in_clear, clk, rst, busy, !done)
  `HTBL_ASSERT_IMP(a_drop_below_token, clk, rst, done && !result.allowed,
                   result.tokens_left < MILLI_PER_TOKEN)
  `HTBL_ASSERT_DLY(a_fixed_latency, clk, rst, start && !busy, 5, done)

endmodule

[rtl/htbl_ram.sv]
// ----------------------------------------------------------------------------
// htbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htbl_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [htbl_pkg::idx_width(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [htbl_pkg::idx_width(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/htbl_index.sv]
// ----------------------------------------------------------------------------
// htbl_index
// Address to bucket index: address modulo the bucket count, two stages.
// Reciprocal multiply gives a quotient at most one short; one
// compare-and-subtract on the low bits finishes the remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htbl_index #(
  parameter int BUCKET_COUNT = 256
) (
  input  logic                                          clk,
  input  logic [htbl_pkg::ADDR_W-1:0]                   addr,
  output logic [htbl_pkg::idx_width(BUCKET_COUNT)-1:0] idx
);

  import htbl_pkg::*;

  localparam int IDX_W = idx_width(BUCKET_COUNT);
  // remainder before correction is below twice the count
  localparam int RW    = IDX_W + 1;
  localparam logic [63:0] RECIP_WIDE = 64'h1_0000_0000 / 64'(BUCKET_COUNT);
  localparam logic [31:0] RECIP      = (RECIP_WIDE > 64'hFFFF_FFFF) ?
                                       32'hFFFF_FFFF : RECIP_WIDE[31:0];
  localparam logic [RW-1:0] DIVISOR  = RW'(BUCKET_COUNT);

  logic [63:0]    prod;
  logic [RW-1:0]  addr_lo;
  logic [RW-1:0]  q_lo;
  logic [RW-1:0]  qn;
  logic [RW-1:0]  rem;
  logic [RW-1:0]  rem_fix;

  // quotient estimate
  assign prod = 64'(addr) * 64'(RECIP);

  // only the low bits of address and quotient matter for the remainder
  always_ff @(posedge clk) begin
    addr_lo <= addr[RW-1:0];
    q_lo    <= prod[32 +: RW];
  end

  // remainder and single correction step
  always_comb begin
    qn      = q_lo * DIVISOR;
    rem     = addr_lo - qn;
    rem_fix = (rem >= DIVISOR) ? (rem - DIVISOR) : rem;
    idx     = rem_fix[IDX_W-1:0];
  end

endmodule

[rtl/htbl_update.sv]
// ----------------------------------------------------------------------------
// htbl_update
// Bucket refill and pass/drop decision for one beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htbl_update (
  input  htbl_pkg::bucket_t             entry,
  input  logic [htbl_pkg::TIME_W-1:0]   time_ms,
  input  htbl_pkg::cfg_t                cfg,
  output htbl_pkg::bucket_t             entry_next,
  output logic                          allowed
);

  import htbl_pkg::*;

  logic [TIME_W-1:0]  dt;
  logic               far;
  logic [PROD_W-1:0]  gain;
  logic               over;
  logic [TOKEN_W:0]   sum;
  logic [TOKEN_W-1:0] refilled;

  always_comb begin
    // wrapping elapsed time
    dt   = time_ms - entry.last_time;
    // 2^20 ms at any non-zero rate is beyond any capacity
    far  = (|dt[TIME_W-1:DT_LOW_W]) && (cfg.rate != '0);
    gain = dt[DT_LOW_W-1:0] * cfg.rate;
    over = far || (gain > PROD_W'(cfg.cap));
    // gain is within capacity here, so its low bits are exact
    sum  = {1'b0, entry.tokens} + {1'b0, gain[TOKEN_W-1:0]};

    if (over) begin
      refilled = cfg.cap;
    end else if (sum > {1'b0, cfg.cap}) begin
      refilled = cfg.cap;
    end else begin
      refilled = sum[TOKEN_W-1:0];
    end

    // one token per packet
    allowed              = (refilled >= MILLI_PER_TOKEN);
    entry_next.last_time = time_ms;
    entry_next.tokens    = allowed ? (refilled - MILLI_PER_TOKEN) : refilled;
  end

endmodule
